@@ design/mpct_pkg.sv @@
// Shared types and constants for the mouse packet cursor tracker.
// No dependencies; every other design file depends on this package.
package mpct_pkg;

  // Coordinate width default and configuration register geometry
  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_W          = 13;
  localparam int CFG_ADDR_W     = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  // Reset values
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;
  localparam int POS_X_RESET = 512;
  localparam int POS_Y_RESET = 384;

  // Header byte layout: sync bit and button field
  localparam int HDR_SYNC_BIT = 3;
  localparam int BUTTON_BITS  = 3;

  // Complete packet handed from the framer to the cursor update
  typedef struct packed {
    logic                   complete;
    logic [7:0]             dx_byte;
    logic [7:0]             dy_byte;
    logic [BUTTON_BITS-1:0] buttons;
  } pkt_t;

endpackage

@@ design/mpct_if.sv @@
// Valid/ready channel interfaces: received bytes in, cursor results out.
// Depends on mpct_pkg for widths.
interface mpct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpct_out_if #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [COORD_BITS-1:0]            cursor_x;
  logic [COORD_BITS-1:0]            cursor_y;
  logic [COORD_BITS-1:0]            old_x;
  logic [COORD_BITS-1:0]            old_y;
  logic [mpct_pkg::BUTTON_BITS-1:0] button_bits;
  logic                             moved;
  logic                             buttons_changed;

  modport source (output valid, output cursor_x, output cursor_y, output old_x,
                  output old_y, output button_bits, output moved,
                  output buttons_changed, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input old_x,
                  input old_y, input button_bits, input moved,
                  input buttons_changed, output ready);
endinterface

@@ design/mpct_framer.sv @@
// Packet framer: tracks the byte phase and holds header and X delta bytes.
// Depends on mpct_pkg for the packet struct and header layout.
module mpct_framer (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     rx_byte,
  output mpct_pkg::pkt_t pkt
);
  import mpct_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  phase_t     phase;
  logic [7:0] header_byte;
  logic [7:0] x_delta_byte;

  // Phase sequencing; a header without the sync bit is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_byte  <= 8'd0;
      x_delta_byte <= 8'd0;
    end else if (step) begin
      case (phase)
        PH_X: begin
          x_delta_byte <= rx_byte;
          phase        <= PH_Y;
        end
        PH_Y: begin
          phase <= PH_HEADER;
        end
        default: begin
          header_byte <= rx_byte;
          phase       <= rx_byte[HDR_SYNC_BIT] ? PH_X : PH_HEADER;
        end
      endcase
    end
  end

  // Third byte completes the packet
  assign pkt.complete = (phase == PH_Y);
  assign pkt.dx_byte  = x_delta_byte;
  assign pkt.dy_byte  = rx_byte;
  assign pkt.buttons  = header_byte[BUTTON_BITS-1:0];

endmodule

@@ design/mpct_cursor.sv @@
// Cursor update: moves and clamps the position, and holds the result register.
// Depends on mpct_pkg and the mpct_out_if interface.
module mpct_cursor #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  mpct_pkg::pkt_t             pkt,
  input  logic [mpct_pkg::CFG_W-1:0] screen_width,
  input  logic [mpct_pkg::CFG_W-1:0] screen_height,
  output logic                       out_free,
  mpct_out_if.source                 out_ch
);
  import mpct_pkg::*;

  localparam int LW = (CFG_W > COORD_BITS + 1) ? CFG_W : COORD_BITS + 1;
  localparam int SW = COORD_BITS + 2;

  logic [COORD_BITS-1:0]  pos_x;
  logic [COORD_BITS-1:0]  pos_y;
  logic [BUTTON_BITS-1:0] last_buttons;
  logic                   valid_q;
  logic [COORD_BITS-1:0]  pos_x_next;
  logic [COORD_BITS-1:0]  pos_y_next;
  logic signed [8:0]      dx;
  logic signed [8:0]      ndy;

  // Largest coordinate for a dimension: zero acts as one, capped at 2^COORD_BITS-1
  function automatic logic [COORD_BITS-1:0] top_of(input logic [CFG_W-1:0] dim);
    logic [LW-1:0] d;
    logic [LW-1:0] cap;
    logic [LW-1:0] t;
    d   = LW'(dim);
    cap = LW'(1) << COORD_BITS;
    if (d == '0) begin
      t = '0;
    end else if (d > cap) begin
      t = cap - LW'(1);
    end else begin
      t = d - LW'(1);
    end
    return t[COORD_BITS-1:0];
  endfunction

  // Add a signed delta and clamp to 0..top
  function automatic logic [COORD_BITS-1:0] move_clamp(
    input logic [COORD_BITS-1:0] pos,
    input logic signed [8:0]     delta,
    input logic [COORD_BITS-1:0] top
  );
    logic signed [SW-1:0] v;
    logic [COORD_BITS-1:0] r;
    v = $signed({2'b00, pos}) + $signed({{(SW-9){delta[8]}}, delta});
    if (v[SW-1]) begin
      r = '0;
    end else if (v[SW-2:0] > {1'b0, top}) begin
      r = top;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // Deltas: X as sent, Y negated (screen y grows downwards)
  assign dx  = {pkt.dx_byte[7], pkt.dx_byte};
  assign ndy = 9'sd0 - $signed({pkt.dy_byte[7], pkt.dy_byte});

  assign pos_x_next = move_clamp(pos_x, dx, top_of(screen_width));
  assign pos_y_next = move_clamp(pos_y, ndy, top_of(screen_height));

  // Result register is free when empty or being taken this cycle
  assign out_free     = !valid_q || out_ch.ready;
  assign out_ch.valid = valid_q;

  // Position state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= COORD_BITS'(POS_X_RESET);
      pos_y        <= COORD_BITS'(POS_Y_RESET);
      last_buttons <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (fire) begin
        pos_x        <= pos_x_next;
        pos_y        <= pos_y_next;
        last_buttons <= pkt.buttons;
        valid_q      <= 1'b1;
      end else if (out_ch.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.cursor_x        <= pos_x_next;
      out_ch.cursor_y        <= pos_y_next;
      out_ch.old_x           <= pos_x;
      out_ch.old_y           <= pos_y;
      out_ch.button_bits     <= pkt.buttons;
      out_ch.moved           <= (pkt.dx_byte != 8'd0) || (pkt.dy_byte != 8'd0);
      out_ch.buttons_changed <= (pkt.buttons != last_buttons);
    end
  end

endmodule

@@ design/mouse_packet_cursor_tracker_top.sv @@
// Top level of the mouse packet cursor tracker: input register, config, assertions.
// Depends on mpct_pkg, mpct_if, mpct_framer and mpct_cursor.
//
// Takes one received mouse byte per cycle and frames three-byte packets; a
// header byte without bit 3 set is dropped to resynchronise. Each completed
// packet moves the cursor by the signed X delta and the negated Y delta,
// clamps it to the screen size held in the two configuration registers, and
// delivers one result word with the new and old position, buttons and change
// flags. A byte is registered in the input register at acceptance and is
// processed from there, and a completed packet's result is registered in the
// result register, where it is offered until it is taken.
// Throughput is one byte per cycle, set by the single input register feeding
// the result register; a byte stalls only when it completes a packet while
// an earlier result is still waiting to be taken.
module mouse_packet_cursor_tracker_top #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mpct_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mpct_pkg::CFG_W-1:0]      cfg_wdata,
  mpct_in_if.sink                         in_ch,
  mpct_out_if.source                      out_ch
);
  import mpct_pkg::*;

  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             step;
  logic             fire;
  logic             out_free;
  pkt_t             pkt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Held byte is consumed unless it completes a packet with the result full
  assign step        = in_valid_q && (!pkt.complete || out_free);
  assign fire        = step && pkt.complete;
  assign in_ch.ready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_q <= in_ch.rx_byte;
    end
  end

  mpct_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte_q),
    .pkt     (pkt)
  );

  mpct_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .pkt           (pkt),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_free      (out_free),
    .out_ch        (out_ch)
  );

  // A completed packet with a blocked result keeps its byte in the input register
  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid_q && pkt.complete && out_ch.valid && !out_ch.ready) |=> in_valid_q)
    else $error("packet byte lost while result register was full");

  // Every processed packet shows up as a result word
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_ch.valid)
    else $error("processed packet produced no result word");

  // No packet is processed into an occupied result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    fire |-> (!out_ch.valid || out_ch.ready))
    else $error("result word overwritten before it was taken");

endmodule
